### hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_RANGES = 16;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [16:0] POOL_LIMIT = 17'h10000;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_FREE    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] start_index;
        logic [16:0] amount;
    } ffra_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_start;
        logic [16:0] granted_length;
        logic [16:0] free_total;
    } ffra_out_t;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] len;
    } ffra_ent_t;

    // request broadcast to every cell
    typedef struct packed {
        logic [15:0] s;
        logic [16:0] amt;
        logic [17:0] send;
    } ffra_req_t;

    typedef struct packed {
        logic lt;        // start < s
        logic fit;       // len >= amt
        logic end_gt;    // start + len > s
        logic end_eq;    // start + len == s
        logic send_gt;   // s + amt > start
        logic send_eq;   // s + amt == start
    } ffra_flags_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SET,
        CMD_LEFT,
        CMD_RIGHT
    } ffra_cmd_t;

endpackage

### hw/rtl/ffra_cell.sv
// ----------------------------------------------------------------------------
// ffra_cell
// One free-list entry: holds a range, compares it against the current
// request and loads from the broadcast value or from either neighbor.
// ----------------------------------------------------------------------------
module ffra_cell (
    input  logic               clk,
    input  ffra_pkg::ffra_cmd_t cmd,
    input  ffra_pkg::ffra_ent_t set_val,
    input  ffra_pkg::ffra_ent_t left,
    input  ffra_pkg::ffra_ent_t right,
    input  ffra_pkg::ffra_req_t req,
    output ffra_pkg::ffra_ent_t ent,
    output ffra_pkg::ffra_flags_t flags
);

    ffra_pkg::ffra_ent_t ent_reg;
    ffra_pkg::ffra_ent_t ent_next;
    logic [17:0]         end_idx;

    assign ent     = ent_reg;
    assign end_idx = {2'b00, ent_reg.start} + {1'b0, ent_reg.len};

    always_comb
    begin
        flags.lt      = ent_reg.start < req.s;
        flags.fit     = ent_reg.len >= req.amt;
        flags.end_gt  = end_idx > {2'b00, req.s};
        flags.end_eq  = end_idx == {2'b00, req.s};
        flags.send_gt = req.send > {2'b00, ent_reg.start};
        flags.send_eq = req.send == {2'b00, ent_reg.start};
    end

    always_comb
    begin
        unique case (cmd)
            ffra_pkg::CMD_SET:   ent_next = set_val;
            ffra_pkg::CMD_LEFT:  ent_next = left;
            ffra_pkg::CMD_RIGHT: ent_next = right;
            default:             ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

### hw/rtl/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator over a sorted, coalesced free list of index ranges.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): mode 0 reserves amount indices
// from the first range large enough; mode 1 returns [start_index,
// start_index+amount) to the list, merging with neighbors where they touch.
// Output channel (out_valid/out_stall/out_data): one result per request with
// status, granted range and the free total after the request.
// A transfer latches the request; in ST_EVAL all 16 cells compare in parallel
// and the shift or merge along the cell row commits once the output register
// is free. No new request is taken until that commit (in_stall is high).
// The result sits in an output register; while the receiver stalls it, one
// more request can be taken and waits until the register frees up.
// Reset loads the pool as one range [0, 65536); the cell row is loaded in
// ST_LOAD, right after reset, during which in_stall is high.
// cfg_we/cfg_wdata write the pool capacity (saturated at 65536) and reset
// the list to a single range (empty for capacity 0); write only while idle.
// ----------------------------------------------------------------------------
module first_fit_range_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffra_pkg::ffra_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffra_pkg::ffra_out_t out_data,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_wdata
);

    localparam int N = ffra_pkg::MAX_RANGES;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t                        state_reg;
    logic [ffra_pkg::CNT_W-1:0]    count_reg;
    logic [ffra_pkg::CNT_W-1:0]    count_next;
    logic [16:0]                   sum_reg;
    logic [16:0]                   sum_next;
    logic [16:0]                   cap_reg;
    logic                          out_valid_reg;
    ffra_pkg::ffra_out_t           out_reg;
    ffra_pkg::ffra_out_t           res_next;
    ffra_pkg::ffra_in_t            req_reg;

    ffra_pkg::ffra_req_t           req;
    ffra_pkg::ffra_ent_t           ent      [N];
    ffra_pkg::ffra_ent_t           left_ent [N];
    ffra_pkg::ffra_ent_t           right_ent[N];
    ffra_pkg::ffra_flags_t         flags    [N];
    ffra_pkg::ffra_cmd_t           cmd      [N];
    ffra_pkg::ffra_ent_t           set_val;

    logic [N-1:0]                  valid_v;
    logic [N-1:0]                  fit_v;
    logic [N-1:0]                  lt_v;
    logic [N-1:0]                  ff_v;
    logic [N-1:0]                  ge_v;
    logic [N-1:0]                  prev_v;
    logic [N-1:0]                  ins_v;
    logic [N-1:0]                  nxt_v;
    logic [N-1:0]                  end_gt_v;
    logic [N-1:0]                  end_eq_v;
    logic [N-1:0]                  send_gt_v;
    logic [N-1:0]                  send_eq_v;
    logic [16:0]                   cap_val;
    logic                          do_commit;

    assign req.s    = req_reg.start_index;
    assign req.amt  = req_reg.amount;
    assign req.send = {2'b00, req_reg.start_index} + {1'b0, req_reg.amount};

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign do_commit = (state_reg == ST_EVAL) && (!out_valid_reg || !out_stall);
    assign cap_val   = (cfg_wdata > ffra_pkg::POOL_LIMIT) ? ffra_pkg::POOL_LIMIT : cfg_wdata;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            ffra_cell u_cell (
                .clk     (clk),
                .cmd     (cmd[g]),
                .set_val (set_val),
                .left    (left_ent[g]),
                .right   (right_ent[g]),
                .req     (req),
                .ent     (ent[g]),
                .flags   (flags[g])
            );
        end
    endgenerate

    // neighbor wiring and per-cell flag vectors
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            left_ent[i]  = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
            right_ent[i] = (i == N - 1) ? '0 : ent[(i == N - 1) ? i : i + 1];
            valid_v[i]   = count_reg > ffra_pkg::CNT_W'(i);
            fit_v[i]     = valid_v[i] && flags[i].fit;
            lt_v[i]      = valid_v[i] && flags[i].lt;
            end_gt_v[i]  = flags[i].end_gt;
            end_eq_v[i]  = flags[i].end_eq;
            send_gt_v[i] = flags[i].send_gt;
            send_eq_v[i] = flags[i].send_eq;
        end
    end

    // first fit, predecessor and insert position
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            ff_v[i] = fit_v[i] && !seen;
            seen    = seen || fit_v[i];
            ge_v[i] = seen;
        end
        prev_v = lt_v & ~({1'b0, lt_v[N-1:1]});
        ins_v  = ~lt_v & {lt_v[N-2:0], 1'b1};
        nxt_v  = ins_v & valid_v;
    end

    always_comb
    begin
        ffra_pkg::ffra_ent_t ff_ent;
        ffra_pkg::ffra_ent_t prv_ent;
        ffra_pkg::ffra_ent_t nxt_ent;
        logic [16:0]         new_len;
        logic [18:0]         merged;
        logic                ignore;
        logic                mp;
        logic                mn;

        ff_ent  = '0;
        prv_ent = '0;
        nxt_ent = '0;
        for (int i = 0; i < N; i++)
        begin
            ff_ent  = ff_ent  | (ff_v[i]   ? ent[i] : '0);
            prv_ent = prv_ent | (prev_v[i] ? ent[i] : '0);
            nxt_ent = nxt_ent | (nxt_v[i]  ? ent[i] : '0);
        end
        new_len = ff_ent.len - req.amt;
        merged  = {2'b00, prv_ent.len} + {2'b00, req.amt} + {2'b00, nxt_ent.len};
        ignore  = (req.amt == '0) || (req.send > {1'b0, cap_reg})
                  || (|(nxt_v & send_gt_v)) || (|(prev_v & end_gt_v));
        mp      = |(prev_v & end_eq_v);
        mn      = |(nxt_v & send_eq_v);

        for (int i = 0; i < N; i++)
        begin
            cmd[i] = ffra_pkg::CMD_HOLD;
        end
        set_val    = '0;
        count_next = count_reg;
        sum_next   = sum_reg;
        res_next   = '0;

        if (req_reg.mode == ffra_pkg::MODE_RESERVE)
        begin
            if (|fit_v)
            begin
                res_next.granted_start  = ff_ent.start;
                res_next.granted_length = req.amt;
                sum_next                = sum_reg - req.amt;
                if (new_len == '0)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (ge_v[i])
                            cmd[i] = ffra_pkg::CMD_RIGHT;
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    set_val.start = ff_ent.start + req.amt[15:0];
                    set_val.len   = new_len;
                    for (int i = 0; i < N; i++)
                    begin
                        if (ff_v[i])
                            cmd[i] = ffra_pkg::CMD_SET;
                    end
                end
            end
            else
            begin
                res_next.status = ffra_pkg::STAT_NOFIT;
            end
        end
        else if (!ignore)
        begin
            if (mp && mn)
            begin
                set_val.start = prv_ent.start;
                set_val.len   = merged[16:0];
                for (int i = 0; i < N; i++)
                begin
                    if (prev_v[i])
                        cmd[i] = ffra_pkg::CMD_SET;
                    else if (!lt_v[i])
                        cmd[i] = ffra_pkg::CMD_RIGHT;
                end
                count_next = count_reg - 1'b1;
                sum_next   = sum_reg + req.amt;
            end
            else if (mp || mn)
            begin
                set_val.start = mp ? prv_ent.start : req.s;
                set_val.len   = (mp ? prv_ent.len : nxt_ent.len) + req.amt;
                for (int i = 0; i < N; i++)
                begin
                    if ((mp && prev_v[i]) || (!mp && nxt_v[i]))
                        cmd[i] = ffra_pkg::CMD_SET;
                end
                sum_next = sum_reg + req.amt;
            end
            else if (count_reg >= ffra_pkg::CNT_W'(N))
            begin
                res_next.status = ffra_pkg::STAT_FULL;
            end
            else
            begin
                set_val.start = req.s;
                set_val.len   = req.amt;
                for (int i = 0; i < N; i++)
                begin
                    if (ins_v[i])
                        cmd[i] = ffra_pkg::CMD_SET;
                    else if (!lt_v[i])
                        cmd[i] = ffra_pkg::CMD_LEFT;
                end
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + req.amt;
            end
        end
        res_next.free_total = sum_next;

        // pool load after reset or capacity write overrides everything
        if (cfg_we || state_reg == ST_LOAD)
        begin
            for (int i = 0; i < N; i++)
            begin
                cmd[i] = (i == 0) ? ffra_pkg::CMD_SET : ffra_pkg::CMD_HOLD;
            end
            set_val.start = '0;
            set_val.len   = cfg_we ? cap_val : cap_reg;
        end
        else if (!do_commit)
        begin
            for (int i = 0; i < N; i++)
            begin
                cmd[i] = ffra_pkg::CMD_HOLD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
        if (do_commit)
            out_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= ffra_pkg::CNT_W'(1);
            sum_reg       <= ffra_pkg::POOL_LIMIT;
            cap_reg       <= ffra_pkg::POOL_LIMIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg   <= cap_val;
                sum_reg   <= cap_val;
                count_reg <= (cap_val != '0) ? ffra_pkg::CNT_W'(1) : '0;
            end
            else if (do_commit)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end

            if (do_commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_LOAD: state_reg <= ST_IDLE;
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (do_commit)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffra_pkg::CNT_W'(N))
        else $error("free list count out of range");

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.free_total <= cap_reg)
        else $error("free total above capacity");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ffra_pkg::STAT_OK)
        |-> (out_reg.granted_length == '0 && out_reg.granted_start == '0))
        else $error("grant reported on failed request");

    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit |=> state_reg == ST_IDLE)
        else $error("request evaluated twice");
`endif

endmodule

### dv/tb_first_fit_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_range_allocator
// Self-checking bench: directed table plus random reserve/free traffic,
// results compared field by field against a behavioral free-list model.
// ----------------------------------------------------------------------------
module tb_first_fit_range_allocator;

    localparam int  WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic                mode;
        int                  start_index;
        int                  amount;
        logic                has_expect;
        ffra_pkg::ffra_out_t expect_res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ffra_pkg::ffra_in_t  in_data;
    logic                out_valid;
    logic                out_stall;
    ffra_pkg::ffra_out_t out_data;
    logic                cfg_we;
    logic [16:0]         cfg_wdata;

    // free list model
    int        cap;
    int        fl_start [ffra_pkg::MAX_RANGES];
    int        fl_len [ffra_pkg::MAX_RANGES];
    int        fl_cnt;
    int        fl_sum;

    ffra_pkg::ffra_out_t pending_results [$];
    int        mismatches;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_recv;
    int        hold_cycles;
    dir_row_t  dir_rows [$];

    first_fit_range_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void load_pool(input int c);
        cap = (c > 65536) ? 65536 : c;
        for (int i = 0; i < ffra_pkg::MAX_RANGES; i++)
        begin
            fl_start[i] = 0;
            fl_len[i] = 0;
        end
        fl_len[0] = cap;
        fl_cnt = (cap != 0) ? 1 : 0;
        fl_sum = cap;
    endfunction

    function automatic void drop_range(input int pos);
        for (int i = pos; i + 1 < fl_cnt; i++)
        begin
            fl_start[i] = fl_start[i + 1];
            fl_len[i] = fl_len[i + 1];
        end
        fl_cnt--;
    endfunction

    function automatic ffra_pkg::ffra_out_t allocate(input ffra_pkg::ffra_in_t req);
        ffra_pkg::ffra_out_t res;
        int        s;
        int        amt;
        int        pos;
        bit        mp;
        bit        mn;
        s = int'(req.start_index);
        amt = int'(req.amount);
        res = '0;
        res.status = ffra_pkg::STAT_OK;
        if (req.mode == ffra_pkg::MODE_RESERVE)
        begin
            res.status = ffra_pkg::STAT_NOFIT;
            for (int i = 0; i < fl_cnt; i++)
            begin
                if (fl_len[i] >= amt)
                begin
                    res.status = ffra_pkg::STAT_OK;
                    res.granted_start = 16'(fl_start[i]);
                    res.granted_length = 17'(amt);
                    fl_start[i] += amt;
                    fl_len[i] -= amt;
                    fl_sum -= amt;
                    if (fl_len[i] == 0)
                        drop_range(i);
                    break;
                end
            end
        end
        else if (amt != 0 && s + amt <= cap)
        begin
            pos = 0;
            while (pos < fl_cnt && fl_start[pos] < s)
                pos++;
            if (!(pos < fl_cnt && s + amt > fl_start[pos]) &&
                !(pos > 0 && fl_start[pos - 1] + fl_len[pos - 1] > s))
            begin
                mp = pos > 0 && fl_start[pos - 1] + fl_len[pos - 1] == s;
                mn = pos < fl_cnt && s + amt == fl_start[pos];
                if (mp && mn)
                begin
                    fl_len[pos - 1] += amt + fl_len[pos];
                    drop_range(pos);
                    fl_sum += amt;
                end
                else if (mp)
                begin
                    fl_len[pos - 1] += amt;
                    fl_sum += amt;
                end
                else if (mn)
                begin
                    fl_start[pos] = s;
                    fl_len[pos] += amt;
                    fl_sum += amt;
                end
                else if (fl_cnt >= ffra_pkg::MAX_RANGES)
                    res.status = ffra_pkg::STAT_FULL;
                else
                begin
                    for (int i = fl_cnt; i > pos; i--)
                    begin
                        fl_start[i] = fl_start[i - 1];
                        fl_len[i] = fl_len[i - 1];
                    end
                    fl_start[pos] = s;
                    fl_len[pos] = amt;
                    fl_cnt++;
                    fl_sum += amt;
                end
            end
        end
        res.free_total = 17'(fl_sum);
        return res;
    endfunction

    // receiver: stall pattern, long hold-off, checking
    always @(posedge clk)
    begin
        if (hold_recv && hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                if (out_data !== pending_results[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 pending_results[0], out_data);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one request, wait for the transfer, record prediction;
    // valid stays up afterwards until the next idle cycle or drain
    task automatic send_req(input ffra_pkg::ffra_in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(allocate(req));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [16:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        load_pool(int'(value));
    endtask

    task automatic add_row(input logic m, input int s, input int a,
                           input logic chk, input ffra_pkg::ffra_out_t r);
        dir_row_t row;
        row.mode = m;
        row.start_index = s;
        row.amount = a;
        row.has_expect = chk;
        row.expect_res = r;
        dir_rows.push_back(row);
    endtask

    // mostly small amounts; most free starts fall inside the pool so merges happen
    function automatic ffra_pkg::ffra_in_t rand_req();
        ffra_pkg::ffra_in_t req;
        int       r;
        req.mode = 1'($urandom_range(1));
        req.start_index = 16'($urandom);
        r = int'($urandom_range(99));
        if (r < 60)
            req.amount = 17'($urandom_range(cap / 24 + 1));
        else if (r < 85)
            req.amount = 17'($urandom_range(cap + 1));
        else
            req.amount = 17'($urandom);
        if (req.mode == ffra_pkg::MODE_FREE && cap > 0 && $urandom_range(99) < 70)
            req.start_index = 16'($urandom_range(cap - 1));
        return req;
    endfunction

    task automatic random_phase(input int n, input int sp, input int rp);
        ffra_pkg::ffra_in_t req;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int i = 0; i < n; i++)
        begin
            req = rand_req();
            send_req(req);
        end
    endtask

    initial
    begin
        ffra_pkg::ffra_in_t req;
        ffra_pkg::ffra_out_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_pool(65536);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset pool, extremes, zero cases, merges, errors
        r = '0; r.free_total = 17'd65536;
        add_row(ffra_pkg::MODE_RESERVE, 0, 0, 1'b1, r);
        r = '0; r.status = ffra_pkg::STAT_NOFIT; r.free_total = 17'd65536;
        add_row(ffra_pkg::MODE_RESERVE, 65535, 65537, 1'b1, r);
        r = '0; r.granted_length = 17'd65536;
        add_row(ffra_pkg::MODE_RESERVE, 0, 65536, 1'b1, r);
        r = '0; r.status = ffra_pkg::STAT_NOFIT;
        add_row(ffra_pkg::MODE_RESERVE, 0, 0, 1'b1, r);
        add_row(ffra_pkg::MODE_FREE, 100, 50, 1'b0, r);   // free into empty list
        add_row(ffra_pkg::MODE_FREE, 90, 10, 1'b0, r);    // merge at the front
        add_row(ffra_pkg::MODE_FREE, 150, 10, 1'b0, r);   // merge with previous
        add_row(ffra_pkg::MODE_FREE, 200, 10, 1'b0, r);
        add_row(ffra_pkg::MODE_FREE, 160, 40, 1'b0, r);   // merge both sides
        add_row(ffra_pkg::MODE_FREE, 120, 5, 1'b0, r);    // overlap, ignored
        add_row(ffra_pkg::MODE_FREE, 300, 0, 1'b0, r);    // zero length
        add_row(ffra_pkg::MODE_FREE, 65535, 2, 1'b0, r);  // past pool end
        add_row(ffra_pkg::MODE_FREE, 65535, 1, 1'b0, r);
        add_row(ffra_pkg::MODE_RESERVE, 0, 20, 1'b0, r);
        for (int i = 0; i < 11; i++)
            add_row(ffra_pkg::MODE_FREE, 1000 + 4 * i, 1, 1'b0, r);
        foreach (dir_rows[i])
        begin
            req.mode = dir_rows[i].mode;
            req.start_index = 16'(dir_rows[i].start_index);
            req.amount = 17'(dir_rows[i].amount);
            send_req(req);
            if (dir_rows[i].has_expect)
                pending_results[$] = dir_rows[i].expect_res;
        end
        // fill the list to overflow
        for (int i = 0; i < 8; i++)
        begin
            req.mode = ffra_pkg::MODE_FREE;
            req.start_index = 16'(2000 + 4 * i);
            req.amount = 17'd1;
            send_req(req);
        end
        drain();

        write_capacity(17'd64);
        random_phase(300, 29, 82);
        write_capacity(17'd0);
        random_phase(20, 0, 0);
        write_capacity(17'h1FFFF);
        random_phase(300, 82, 29);
        write_capacity(17'd1);
        random_phase(60, 0, 0);
        write_capacity(17'd300);

        // receiver holds off while requests keep coming
        hold_recv <= 1'b1;
        @(posedge clk);
        hold_cycles <= 60;
        random_phase(20, 0, 0);
        hold_recv <= 1'b0;
        drain();

        write_capacity(17'd2000);
        random_phase(500, 0, 0);
        write_capacity(17'd65535);
        random_phase(500, 10, 10);
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
